### rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Shared constants, beat type and helper functions for the XTEA pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

    // Number of full Feistel cycles per block.
    localparam int ROUNDS = 32;
    // Each pipeline stage performs one half of a Feistel cycle.
    localparam int STAGES = 2 * ROUNDS;
    // Cycles from an accepted start to the result strobe.
    localparam int LATENCY = STAGES;

    localparam int WORD_W    = 32;
    localparam int KEY_WORDS = 4;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_SHIFT = 11;

    // Golden-ratio delta; the step is added as the negation of NEG_DELTA.
    localparam logic [WORD_W-1:0] NEG_DELTA = 32'h61C88647;
    localparam logic [WORD_W-1:0] DELTA     = 32'h9E3779B9;

    // Action codes.
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // Half-cycle phase codes.
    localparam logic PHASE_A = 1'b0;
    localparam logic PHASE_B = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    // One block traveling down the pipeline.
    typedef struct packed {
        logic              valid;
        logic              action;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } t_beat;

    // Round sum after n delta steps, worked out at elaboration.
    function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(n) * 64'(DELTA);
        return prod[WORD_W-1:0];
    endfunction

    // The XTEA shift-xor-add mixing function.
    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

### rtl/xtea_stage.sv
// ----------------------------------------------------------------------------
// XTEA half-cycle stage
// Updates one word of the block by one Feistel half cycle and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_phase,
    input  wire logic [xtea_pkg::WORD_W-1:0]  i_sum_enc,
    input  wire logic [xtea_pkg::WORD_W-1:0]  i_sum_dec,
    input  wire xtea_pkg::t_key               i_key,
    input  wire xtea_pkg::t_beat              i_beat,
    output xtea_pkg::t_beat                   o_beat
);
    import xtea_pkg::*;

    logic                 use_low;
    logic [WORD_W-1:0]    sum;
    logic [1:0]           key_idx;
    logic [WORD_W-1:0]    src;
    logic [WORD_W-1:0]    dst;
    logic [WORD_W-1:0]    f;
    logic [WORD_W-1:0]    n_dst;
    t_beat                r_beat;
    t_beat                n_beat;

    // Encryption updates v0 in phase A, decryption updates v1 in phase A;
    // the low key select goes with the v0 update in both directions.
    always_comb begin
        use_low = (i_beat.action == i_phase);
        sum     = (i_beat.action == ACT_DECRYPT) ? i_sum_dec : i_sum_enc;
        key_idx = use_low ? sum[1:0] : sum[KEY_SHIFT+1:KEY_SHIFT];
        src     = use_low ? i_beat.v1 : i_beat.v0;
        dst     = use_low ? i_beat.v0 : i_beat.v1;
        f       = mix(src) ^ (sum + i_key[key_idx]);
        n_dst   = (i_beat.action == ACT_DECRYPT) ? (dst - f) : (dst + f);
    end

    // Assemble the next beat with the updated word in place.
    always_comb begin
        n_beat        = i_beat;
        n_beat.valid  = i_beat.valid;
        if (use_low) begin
            n_beat.v0 = n_dst;
        end else begin
            n_beat.v1 = n_dst;
        end
    end

    // Stage register; only the valid bit needs reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.action <= n_beat.action;
        r_beat.v0     <= n_beat.v0;
        r_beat.v1     <= n_beat.v1;
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

### rtl/xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// XTEA block cipher
// Fully pipelined 64-bit XTEA encrypt/decrypt with a 128-bit key.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// config    in         i_cfg_we               i_cfg_index, i_cfg_data
// block     in         i_start (o_busy low)   i_action, i_block_first/second
// result    out        o_valid strobe         o_out_first, o_out_second
//
// One block is accepted every cycle; each result passes through one
// pipeline stage per Feistel half cycle. o_busy stays low because the
// pipeline never stalls. Synchronous reset clears the key and all valid
// bits; blocks in flight are dropped. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_block_cipher (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]    i_cfg_data,
    input  wire logic                           i_start,
    output      logic                           o_busy,
    input  wire logic                           i_action,
    input  wire logic [xtea_pkg::WORD_W-1:0]    i_block_first,
    input  wire logic [xtea_pkg::WORD_W-1:0]    i_block_second,
    output      logic                           o_valid,
    output      logic [xtea_pkg::WORD_W-1:0]    o_out_first,
    output      logic [xtea_pkg::WORD_W-1:0]    o_out_second
);
    import xtea_pkg::*;

    t_key  r_key;
    t_beat w_beat [0:STAGES];

    // Key registers, written at any cycle the write enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // The pipeline takes a new block every cycle.
    assign o_busy = 1'b0;

    always_comb begin
        w_beat[0].valid  = i_start && !o_busy;
        w_beat[0].action = i_action;
        w_beat[0].v0     = i_block_first;
        w_beat[0].v1     = i_block_second;
    end

    // One stage per half cycle, each with its own fixed round sums.
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam int          R      = g / 2;
        localparam logic        PH     = (g % 2 == 1) ? PHASE_B : PHASE_A;
        localparam int unsigned N_ENC  = (g % 2 == 1) ? R + 1 : R;
        localparam int unsigned N_DEC  = (g % 2 == 1) ? ROUNDS - R - 1 : ROUNDS - R;
        localparam logic [WORD_W-1:0] SUM_ENC = round_sum(N_ENC);
        localparam logic [WORD_W-1:0] SUM_DEC = round_sum(N_DEC);

        xtea_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_phase   (PH),
            .i_sum_enc (SUM_ENC),
            .i_sum_dec (SUM_DEC),
            .i_key     (r_key),
            .i_beat    (w_beat[g]),
            .o_beat    (w_beat[g+1])
        );
    end

    // The last stage register drives the result ports.
    assign o_valid      = w_beat[STAGES].valid;
    assign o_out_first  = w_beat[STAGES].v0;
    assign o_out_second = w_beat[STAGES].v1;

endmodule

`default_nettype wire

### rtl/xtea_checker.sv
// ----------------------------------------------------------------------------
// XTEA port checker
// Watches the top-level ports for latency, reset and consistency slips.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [xtea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [xtea_pkg::WORD_W-1:0]    i_cfg_data,
    input  wire logic                           i_start,
    input  wire logic                           o_busy,
    input  wire logic                           i_action,
    input  wire logic [xtea_pkg::WORD_W-1:0]    i_block_first,
    input  wire logic [xtea_pkg::WORD_W-1:0]    i_block_second,
    input  wire logic                           o_valid,
    input  wire logic [xtea_pkg::WORD_W-1:0]    o_out_first,
    input  wire logic [xtea_pkg::WORD_W-1:0]    o_out_second
);
    import xtea_pkg::*;

    // Every result beat traces back to an accepted start a fixed time ago.
    a_result_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("result beat without a matching start");

    // Reset flushes every block in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result beat right after reset");

    // The pipeline never holds off a start.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_start) |-> !o_busy)
        else $error("busy raised while the pipeline streams");

    // A key write carries a known index and value.
    a_cfg_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !$isunknown({i_cfg_index, i_cfg_data}))
        else $error("key write with unknown index or data");

    // Two back-to-back equal blocks with the same action give equal results; the key is not part of the match.
    a_same_in_same_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid)
            && $past(i_action, LATENCY) == $past(i_action, LATENCY + 1)
            && $past(i_block_first, LATENCY) == $past(i_block_first, LATENCY + 1)
            && $past(i_block_second, LATENCY) == $past(i_block_second, LATENCY + 1))
        |-> (o_out_first == $past(o_out_first) && o_out_second == $past(o_out_second)))
        else $error("equal blocks gave different results");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (.*);

`default_nettype wire
